[rtl/tcd_pkg.sv]
package tcd_pkg;

  // pipeline depth, input register to result register
  localparam int unsigned STAGES = 11;

  // stream widths
  localparam int unsigned TS_W        = 59;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 64;

  // day split: 86400e6 us = 2^13 * 10546875
  localparam int unsigned   DAY_SHIFT = 13;
  localparam logic [23:0]   DAY_DIV   = 24'd10546875;
  // bias of 2^22 days keeps the shifted stamp positive
  localparam logic [46:0]   DAY_BIAS  = 47'd44236800000000;
  // floor(2^48 / DAY_DIV), estimate is at most one low
  localparam logic [24:0]   DAY_RECIP = 25'((64'd1 << 48) / 64'd10546875);
  // biased day count to julian day number
  localparam logic [23:0]   JDN_OFS   = 24'd1742759;
  // 4 * (jdn - 1867216) - 1 taken straight from the biased day count
  localparam logic [26:0]   X_OFS     = 27'd14439901;

  // exact reciprocals, ceil(2^s / d), s = dividend bits + ceil(log2 d); MONTH and DOM scaled by 10000 and 306001
  localparam logic [24:0]   ALPHA_RECIP = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
  localparam logic [28:0]   CYC_RECIP   = 29'(((64'd1 << 42) + 64'd14609) / 64'd14610);
  localparam logic [37:0]   MONTH_RECIP =
    38'(64'd10000 * (((64'd1 << 42) + 64'd306000) / 64'd306001));
  localparam logic [41:0]   DOM_RECIP   =
    42'(64'd306001 * (((64'd1 << 37) + 64'd9999) / 64'd10000));

  // time of day: hour = 2^10 * 3515625 us, minute = 2^8 * 234375 us
  localparam logic [21:0]   HOUR_DIV   = 22'd3515625;
  localparam logic [27:0]   HOUR_RECIP = 28'(((64'd1 << 49) + 64'd3515624) / 64'd3515625);
  localparam logic [17:0]   MIN_DIV    = 18'd234375;
  localparam logic [24:0]   MIN_RECIP  = 25'(((64'd1 << 42) + 64'd234374) / 64'd234375);

  // date offsets
  localparam logic [23:0]   B_OFS    = 24'd1525;
  localparam logic [29:0]   Y_OFS    = 30'd4884;
  localparam logic [16:0]   YEAR_OFS = 17'd4715;

  // bound on the time of day shifted down by 10 bits
  localparam logic [26:0]   TOD_HI_LIMIT = 27'd84375000;

endpackage

[rtl/timestamp_to_civil_date.sv]
// Converts a signed microsecond count since 2000-01-01T00:00 into the proleptic
// Gregorian year, month and day plus hour, minute and microseconds within the
// minute. The block is an 11-stage pipeline with skid-free bubble collapsing:
// it takes one request per clock unless every stage holds data and the output
// side stalls. The depth is set by the chain of constant divisions (day split,
// century correction, year, month and day), each done as a registered multiply
// by an exact reciprocal. Time-of-day fields are exact for any input; the date
// fields follow the integer steps of the alpha / 365.25 / 30.6001 method for
// every input bit pattern.
module timestamp_to_civil_date (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [58:0] micros_since_2000
  input  logic [tcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [13:0] year, [17:14] month, [22:18] day_of_month, [27:23] hour,
  // [33:28] minute, [59:34] micros_in_minute
  output logic [tcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // stage valid bits and ready chain
  logic [tcd_pkg::STAGES-1:0] vld_q;
  logic [tcd_pkg::STAGES-1:0] rdy;

  always_comb begin
    rdy[tcd_pkg::STAGES-1] = !vld_q[tcd_pkg::STAGES-1] || m_axis_tready;
    for (int i = tcd_pkg::STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy) | (rdy & {vld_q[tcd_pkg::STAGES-2:0], s_axis_tvalid});
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[tcd_pkg::STAGES-1];

  // stage 1: input register
  logic [tcd_pkg::TS_W-1:0] s1_t_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_t_q <= s_axis_tdata[tcd_pkg::TS_W-1:0];
    end
  end

  // stage 2: drop the power-of-two part of a day and bias positive
  logic [46:0] s2_v_d;
  logic [46:0] s2_v_q;
  logic [12:0] s2_lo_q;

  assign s2_v_d = {s1_t_q[tcd_pkg::TS_W-1], s1_t_q[tcd_pkg::TS_W-1:tcd_pkg::DAY_SHIFT]}
                  + tcd_pkg::DAY_BIAS;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_v_q  <= s2_v_d;
      s2_lo_q <= s1_t_q[tcd_pkg::DAY_SHIFT-1:0];
    end
  end

  // stage 3: day quotient estimate from the top bits
  logic [51:0] s3_prod;
  logic [23:0] s3_q0_q;
  logic [24:0] s3_vl_q;
  logic [12:0] s3_lo_q;

  assign s3_prod = 52'(s2_v_q[46:20]) * 52'(tcd_pkg::DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_q0_q <= s3_prod[51:28];
      s3_vl_q <= s2_v_q[24:0];
      s3_lo_q <= s2_lo_q;
    end
  end

  // stage 4: remainder of the estimate, below twice the divisor
  logic [47:0] s4_qd;
  logic [24:0] s4_r0_d;
  logic [24:0] s4_r0_q;
  logic [23:0] s4_q0_q;
  logic [12:0] s4_lo_q;

  assign s4_qd   = 48'(s3_q0_q) * 48'(tcd_pkg::DAY_DIV);
  assign s4_r0_d = s3_vl_q - s4_qd[24:0];

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_r0_q <= s4_r0_d;
      s4_q0_q <= s3_q0_q;
      s4_lo_q <= s3_lo_q;
    end
  end

  // stage 5: correct the day quotient, form the julian day and alpha dividend
  logic        s5_corr;
  logic [23:0] s5_q;
  logic [23:0] s5_r;
  logic [26:0] s5_x;
  logic [23:0] s5_jdn_d;
  logic [23:0] s5_ax_d;
  logic [26:0] s5_w2_d;
  logic [23:0] s5_jdn_q;
  logic [23:0] s5_ax_q;
  logic        s5_sx_q;
  logic [26:0] s5_w2_q;
  logic [9:0]  s5_lo_q;

  always_comb begin
    s5_corr  = (s4_r0_q >= {1'b0, tcd_pkg::DAY_DIV});
    s5_q     = s4_q0_q + {23'd0, s5_corr};
    s5_r     = s5_corr ? 24'(s4_r0_q - {1'b0, tcd_pkg::DAY_DIV}) : s4_r0_q[23:0];
    s5_jdn_d = s5_q - tcd_pkg::JDN_OFS;
    s5_x     = {1'b0, s5_q, 2'b00} - tcd_pkg::X_OFS;
    s5_ax_d  = s5_x[26] ? 24'(-s5_x) : s5_x[23:0];
    s5_w2_d  = {s5_r, s4_lo_q[12:10]};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_jdn_q <= s5_jdn_d;
      s5_ax_q  <= s5_ax_d;
      s5_sx_q  <= s5_x[26];
      s5_w2_q  <= s5_w2_d;
      s5_lo_q  <= s4_lo_q[9:0];
    end
  end

  // stage 6: alpha magnitude and hour
  logic [48:0] s6_aprod;
  logic [54:0] s6_hprod;
  logic [23:0] s6_jdn_q;
  logic [6:0]  s6_qa_q;
  logic        s6_sx_q;
  logic [26:0] s6_w2_q;
  logic [4:0]  s6_hr_q;
  logic [9:0]  s6_lo_q;

  assign s6_aprod = 49'(s5_ax_q) * 49'(tcd_pkg::ALPHA_RECIP);
  assign s6_hprod = 55'(s5_w2_q) * 55'(tcd_pkg::HOUR_RECIP);

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_jdn_q <= s5_jdn_q;
      s6_qa_q  <= s6_aprod[48:42];
      s6_sx_q  <= s5_sx_q;
      s6_w2_q  <= s5_w2_q;
      s6_hr_q  <= s6_hprod[53:49];
      s6_lo_q  <= s5_lo_q;
    end
  end

  // stage 7: b = jdn + 1525 + alpha - alpha/4, remainder within the hour
  logic [6:0]  s7_g;
  logic [23:0] s7_b_d;
  logic [26:0] s7_hx;
  logic [26:0] s7_rem;
  logic [23:0] s7_b_q;
  logic [4:0]  s7_hr_q;
  logic [23:0] s7_w3_q;
  logic [7:0]  s7_lo_q;

  always_comb begin
    s7_g   = s6_qa_q - (s6_qa_q >> 2);
    s7_b_d = s6_sx_q ? s6_jdn_q + tcd_pkg::B_OFS - {17'd0, s7_g}
                     : s6_jdn_q + tcd_pkg::B_OFS + {17'd0, s7_g};
    s7_hx  = 27'(s6_hr_q) * 27'(tcd_pkg::HOUR_DIV);
    s7_rem = s6_w2_q - s7_hx;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_b_q  <= s7_b_d;
      s7_hr_q <= s6_hr_q;
      s7_w3_q <= {s7_rem[21:0], s6_lo_q[9:8]};
      s7_lo_q <= s6_lo_q[7:0];
    end
  end

  // stage 8: year cycle count c from (40b - 4884) / 14610, and minute
  logic [29:0] s8_be;
  logic [29:0] s8_y;
  logic [27:0] s8_ay;
  logic [56:0] s8_cprod;
  logic [48:0] s8_mprod;
  logic [23:0] s8_b_q;
  logic [14:0] s8_qc_q;
  logic        s8_sy_q;
  logic [4:0]  s8_hr_q;
  logic [5:0]  s8_mn_q;
  logic [23:0] s8_w3_q;
  logic [7:0]  s8_lo_q;

  always_comb begin
    s8_be    = {{6{s7_b_q[23]}}, s7_b_q};
    s8_y     = (s8_be << 5) + (s8_be << 3) - tcd_pkg::Y_OFS;
    s8_ay    = s8_y[29] ? 28'(-s8_y) : s8_y[27:0];
    s8_cprod = 57'(s8_ay) * 57'(tcd_pkg::CYC_RECIP);
    s8_mprod = 49'(s7_w3_q) * 49'(tcd_pkg::MIN_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_b_q  <= s7_b_q;
      s8_qc_q <= s8_cprod[56:42];
      s8_sy_q <= s8_y[29];
      s8_hr_q <= s7_hr_q;
      s8_mn_q <= s8_mprod[47:42];
      s8_w3_q <= s7_w3_q;
      s8_lo_q <= s7_lo_q;
    end
  end

  // stage 9: d = 365c + c/4, days left z = b - d, microseconds in minute
  logic [22:0] s9_dmag;
  logic [23:0] s9_z;
  logic [15:0] s9_c_d;
  logic [23:0] s9_mx;
  logic [23:0] s9_urem;
  logic [9:0]  s9_z_q;
  logic [15:0] s9_c_q;
  logic [4:0]  s9_hr_q;
  logic [5:0]  s9_mn_q;
  logic [25:0] s9_us_q;

  always_comb begin
    s9_dmag = 23'(s8_qc_q) * 23'd365 + 23'(s8_qc_q >> 2);
    s9_z    = s8_sy_q ? s8_b_q + {1'b0, s9_dmag} : s8_b_q - {1'b0, s9_dmag};
    s9_c_d  = s8_sy_q ? -{1'b0, s8_qc_q} : {1'b0, s8_qc_q};
    s9_mx   = 24'(s8_mn_q) * 24'(tcd_pkg::MIN_DIV);
    s9_urem = s8_w3_q - s9_mx;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s9_z_q  <= s9_z[9:0];
      s9_c_q  <= s9_c_d;
      s9_hr_q <= s8_hr_q;
      s9_mn_q <= s8_mn_q;
      s9_us_q <= {s9_urem[17:0], s8_lo_q};
    end
  end

  // stage 10: e = 10000z / 306001, as a magnitude and a sign
  logic [9:0]  s10_az;
  logic [47:0] s10_eprod;
  logic [9:0]  s10_z_q;
  logic [15:0] s10_c_q;
  logic [3:0]  s10_emag_q;
  logic        s10_ez_q;
  logic [4:0]  s10_hr_q;
  logic [5:0]  s10_mn_q;
  logic [25:0] s10_us_q;

  always_comb begin
    s10_az    = s9_z_q[9] ? 10'(-s9_z_q) : s9_z_q;
    s10_eprod = 48'(s10_az) * 48'(tcd_pkg::MONTH_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      s10_z_q    <= s9_z_q;
      s10_c_q    <= s9_c_q;
      s10_emag_q <= s10_eprod[45:42];
      s10_ez_q   <= s9_z_q[9];
      s10_hr_q   <= s9_hr_q;
      s10_mn_q   <= s9_mn_q;
      s10_us_q   <= s9_us_q;
    end
  end

  // stage 11: day of month, month and year into the result register
  logic [45:0] s11_fprod;
  logic [8:0]  s11_fmag;
  logic [10:0] s11_zx;
  logic [10:0] s11_dom;
  logic [5:0]  s11_e;
  logic [5:0]  s11_em2;
  logic [5:0]  s11_wrap;
  logic [5:0]  s11_mon;
  logic        s11_late;
  logic [16:0] s11_yr0;
  logic [16:0] s11_yr;
  logic [13:0] out_yr_q;
  logic [3:0]  out_mon_q;
  logic [4:0]  out_dom_q;
  logic [4:0]  out_hr_q;
  logic [5:0]  out_mn_q;
  logic [25:0] out_us_q;

  always_comb begin
    s11_fprod = 46'(s10_emag_q) * 46'(tcd_pkg::DOM_RECIP);
    s11_fmag  = s11_fprod[45:37];
    s11_zx    = {s10_z_q[9], s10_z_q};
    s11_dom   = s10_ez_q ? s11_zx + {2'b00, s11_fmag} : s11_zx - {2'b00, s11_fmag};
    s11_e     = s10_ez_q ? -{2'b00, s10_emag_q} : {2'b00, s10_emag_q};
    s11_em2   = s11_e - 6'd2;
    // remainder by 12 keeps the sign of the dividend
    if ($signed(s11_em2) >= 6'sd12) begin
      s11_wrap = s11_em2 - 6'd12;
    end else if ($signed(s11_em2) <= -6'sd12) begin
      s11_wrap = s11_em2 + 6'd12;
    end else begin
      s11_wrap = s11_em2;
    end
    s11_mon  = s11_wrap + 6'd1;
    s11_late = $signed(s11_mon) > 6'sd2;
    s11_yr0  = {s10_c_q[15], s10_c_q} - tcd_pkg::YEAR_OFS - {16'd0, s11_late};
    // no year zero
    s11_yr   = ($signed(s11_yr0) <= 17'sd0) ? s11_yr0 - 17'd1 : s11_yr0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      out_yr_q  <= s11_yr[13:0];
      out_mon_q <= s11_mon[3:0];
      out_dom_q <= s11_dom[4:0];
      out_hr_q  <= s10_hr_q;
      out_mn_q  <= s10_mn_q;
      out_us_q  <= s10_us_q;
    end
  end

  assign m_axis_tdata = {4'd0, out_us_q, out_mn_q, out_hr_q, out_dom_q, out_mon_q, out_yr_q};

  // time-of-day fields are always in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_hr_q < 5'd24) && (out_mn_q < 6'd60) && (out_us_q < 26'd60000000))
    else $error("time of day field out of range");

  // corrected day remainder stays below one day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (s5_w2_q < tcd_pkg::TOD_HI_LIMIT))
    else $error("day split remainder out of range");

  // days left after the year step stay within one year and a season
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> ($signed(s9_z_q) >= -10'sd245) && ($signed(s9_z_q) <= 10'sd489))
    else $error("day within year out of range");

  // input is held off only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("pipeline stalls with a free stage");

endmodule
